/* design/cfsa_pkg.sv */
// ----------------------------------------------------------------------------
// Circular free-slot allocator package
// Field widths, codes and the command and status bundles shared by the
// controller and the datapath.
// ----------------------------------------------------------------------------
package cfsa_pkg;

   localparam int SLOT_W     = 8;
   localparam int RING_W     = 9;
   localparam int WORD_BITS  = 32;
   localparam int WORD_W     = 5;
   localparam int SLOT_LIMIT = 256;

   localparam logic KIND_ENTER = 1'b0;
   localparam logic KIND_LEAVE = 1'b1;

   localparam logic STATUS_GRANTED = 1'b0;
   localparam logic STATUS_FULL    = 1'b1;

   typedef struct packed {
      logic load_enter;
      logic clear_slot;
      logic div_step;
      logic scan_init;
      logic scan_next;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic slot_in_ring;
      logic found;
      logic exhausted;
      logic out_free;
   } status_type;

endpackage

/* design/cfsa_req_if.sv */
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one enter or leave request per beat.
// ----------------------------------------------------------------------------
interface cfsa_req_if;
   logic                        valid;
   logic                        ready;
   logic                        kind;
   logic [cfsa_pkg::SLOT_W-1:0] slot;

   modport source (output valid, kind, slot, input ready);
   modport sink   (input valid, kind, slot, output ready);
endinterface

/* design/cfsa_rsp_if.sv */
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries one grant result per beat.
// ----------------------------------------------------------------------------
interface cfsa_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [cfsa_pkg::SLOT_W-1:0] granted_slot;
   logic                        status;

   modport source (output valid, granted_slot, status, input ready);
   modport sink   (input valid, granted_slot, status, output ready);
endinterface

/* design/cfsa_datapath.sv */
// ----------------------------------------------------------------------------
// Allocator datapath
// Occupancy bitmap, ring size register, bit-serial remainder unit, word
// scanner with wrap and the response register.
// ----------------------------------------------------------------------------
module cfsa_datapath #(
   parameter int MAX_SLOTS = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [cfsa_pkg::RING_W-1:0]   csr_wr_data,
   input  logic [cfsa_pkg::SLOT_W-1:0]   req_slot,
   input  logic                          rsp_ready,
   input  cfsa_pkg::cmd_type             cmd,
   output cfsa_pkg::status_type          sts,
   output logic                          rsp_valid,
   output logic [cfsa_pkg::SLOT_W-1:0]   rsp_granted_slot,
   output logic                          rsp_status
);
   import cfsa_pkg::*;

   localparam int DEPTH  = (MAX_SLOTS < SLOT_LIMIT) ? MAX_SLOTS : SLOT_LIMIT;
   localparam int NWORDS = (DEPTH + WORD_BITS - 1) / WORD_BITS;
   localparam int WIDX_W = (NWORDS > 1) ? $clog2(NWORDS) : 1;

   logic [RING_W-1:0]    ring_cfg_ff;
   logic [WORD_BITS-1:0] occ_ff [NWORDS];
   logic [SLOT_W-1:0]    pos_ff;
   logic [SLOT_W-1:0]    div_ff;
   logic [WIDX_W-1:0]    widx_ff;
   logic                 pass_ff;
   logic                 rsp_valid_ff;
   logic [SLOT_W-1:0]    rsp_slot_ff;
   logic                 rsp_status_ff;

   logic [RING_W-1:0]    ring_size;
   logic [RING_W-1:0]    ring_last;
   logic [WIDX_W-1:0]    last_widx;
   logic [WIDX_W-1:0]    first_widx;
   logic                 last_word;
   logic [WORD_BITS-1:0] free_bits;
   logic [WORD_W-1:0]    sel;
   logic                 found;
   logic [SLOT_W-1:0]    grant_slot;
   logic [RING_W-1:0]    rem_shift;
   logic [SLOT_W-1:0]    rem_in;

   always_comb begin
      if (ring_cfg_ff == '0) begin
         ring_size = RING_W'(1);
      end else if (ring_cfg_ff > RING_W'(DEPTH)) begin
         ring_size = RING_W'(DEPTH);
      end else begin
         ring_size = ring_cfg_ff;
      end
   end

   assign ring_last  = ring_size - RING_W'(1);
   assign last_widx  = ring_last[WORD_W +: WIDX_W];
   assign first_widx = pos_ff[WORD_W +: WIDX_W];
   assign last_word  = pass_ff ? (widx_ff == first_widx) : (widx_ff == last_widx);

   always_comb begin
      logic [RING_W-1:0] g;
      for (int b = 0; b < WORD_BITS; b++) begin
         g = RING_W'({widx_ff, WORD_W'(b)});
         free_bits[b] = !occ_ff[widx_ff][b] && (g < ring_size) &&
                        (pass_ff || (g >= {1'b0, pos_ff}));
      end
   end

   always_comb begin
      sel   = '0;
      found = 1'b0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (free_bits[b]) begin
            sel   = WORD_W'(b);
            found = 1'b1;
         end
      end
   end

   assign grant_slot = SLOT_W'({widx_ff, sel});

   assign rem_shift = {pos_ff, div_ff[SLOT_W-1]};
   assign rem_in    = (rem_shift >= ring_size) ? SLOT_W'(rem_shift - ring_size)
                                               : SLOT_W'(rem_shift);

   assign sts.slot_in_ring = ({1'b0, req_slot} < ring_size);
   assign sts.found        = found;
   assign sts.exhausted    = !found && last_word && pass_ff;
   assign sts.out_free     = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_cfg_ff <= RING_W'(SLOT_LIMIT);
         for (int w = 0; w < NWORDS; w++) begin
            occ_ff[w] <= '0;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            ring_cfg_ff <= csr_wr_data;
         end
         if (cmd.clear_slot) begin
            occ_ff[req_slot[WORD_W +: WIDX_W]][req_slot[WORD_W-1:0]] <= 1'b0;
         end
         if (cmd.commit && found) begin
            occ_ff[widx_ff][sel] <= 1'b1;
         end
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_enter) begin
         pos_ff <= sts.slot_in_ring ? req_slot : '0;
         div_ff <= req_slot;
      end else if (cmd.div_step) begin
         pos_ff <= rem_in;
         div_ff <= {div_ff[SLOT_W-2:0], 1'b0};
      end
      if (cmd.scan_init) begin
         widx_ff <= first_widx;
         pass_ff <= 1'b0;
      end else if (cmd.scan_next) begin
         if (last_word) begin
            widx_ff <= '0;
            pass_ff <= 1'b1;
         end else begin
            widx_ff <= widx_ff + WIDX_W'(1);
         end
      end
      if (cmd.commit) begin
         rsp_slot_ff   <= found ? grant_slot : '0;
         rsp_status_ff <= found ? STATUS_GRANTED : STATUS_FULL;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_granted_slot = rsp_slot_ff;
   assign rsp_status       = rsp_status_ff;

endmodule

/* design/cfsa_controller.sv */
// ----------------------------------------------------------------------------
// Allocator controller
// Sequences request intake, remainder steps, word scan and commit.
// ----------------------------------------------------------------------------
module cfsa_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_kind,
   output logic                 req_ready,
   input  cfsa_pkg::status_type sts,
   output cfsa_pkg::cmd_type    cmd
);
   import cfsa_pkg::*;

   localparam int CNT_W = $clog2(SLOT_W);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_START,
      ST_SCAN
   } state_type;

   state_type        state_ff;
   state_type        state_in;
   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_in;
   logic             accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (accept && req_kind == KIND_LEAVE) begin
               cmd.clear_slot = sts.slot_in_ring;
            end else if (accept) begin
               cmd.load_enter = 1'b1;
               state_in       = sts.slot_in_ring ? ST_START : ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(SLOT_W - 1)) begin
               state_in = ST_START;
            end
         end
         ST_START: begin
            cmd.scan_init = 1'b1;
            state_in      = ST_SCAN;
         end
         ST_SCAN: begin
            if (sts.found || sts.exhausted) begin
               if (sts.out_free) begin
                  cmd.commit = 1'b1;
                  state_in   = ST_IDLE;
               end
            end else begin
               cmd.scan_next = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

/* design/circular_free_slot_allocator_top.sv */
// ----------------------------------------------------------------------------
// Circular free-slot allocator
// Grants the first free slot at or after a preferred slot around a ring of
// configurable size; frees slots on leave requests.
// ----------------------------------------------------------------------------
// Leave: taken with no response; next request accepted the cycle after.
// Enter: 8 remainder steps when the preferred slot lies beyond the ring, then
//   scan start, a scan of S words (1 to W+1, W = ring size / 32 rounded up),
//   then commit to the response beat. The word scanner reads one 32-bit word a cycle.
// One request in flight; a finished response waits in its output register.
// Reset: synchronous, clears the whole occupancy bitmap at once, ring size 256 (clamped to MAX_SLOTS).
module circular_free_slot_allocator_top #(
   parameter int MAX_SLOTS = 256
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [cfsa_pkg::RING_W-1:0] csr_wr_data,
   cfsa_req_if.sink                    req_ch,
   cfsa_rsp_if.source                  rsp_ch
);
   import cfsa_pkg::*;

   cmd_type    cmd;
   status_type sts;

   cfsa_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_kind  (req_ch.kind),
      .req_ready (req_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   cfsa_datapath #(
      .MAX_SLOTS (MAX_SLOTS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_slot         (req_ch.slot),
      .rsp_ready        (rsp_ch.ready),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_valid        (rsp_ch.valid),
      .rsp_granted_slot (rsp_ch.granted_slot),
      .rsp_status       (rsp_ch.status)
   );

   a_full_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.status == STATUS_FULL |-> rsp_ch.granted_slot == '0)
      else $error("full response carries nonzero slot");

   a_commit_room: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> sts.out_free)
      else $error("commit while response register occupied");

   a_commit_beat: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_ch.valid)
      else $error("commit did not raise response valid");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      req_ch.ready |-> !cmd.scan_next && !cmd.commit && !cmd.div_step)
      else $error("request accepted while an enter is in progress");

endmodule
